// ===== hw/rtl/evsc_pkg.sv =====
`default_nettype none
package evsc_pkg;

    localparam int IN_TDATA_W  = 248;
    localparam int OUT_TDATA_W = 128;
    localparam int COEFF_W     = 20;
    localparam int COEFF_RESET = 65536;

    // one stage per result bit of the square root and of the quotient
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int TAIL_STAGES = SQRT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] npx;
        logic signed [31:0] npy;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               cap;
        logic               negx;
        logic               negy;
        logic [62:0]        dvx;
        logic [62:0]        dvy;
        logic [63:0]        n;
        logic [63:0]        res;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic [30:0]        qx;
        logic [30:0]        qy;
    } tail_t;

    // clamp to 32-bit signed; bit 32 of the result is the clamp flag
    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > 64'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (x < -64'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, x[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/euler_velocity_speed_cap.sv =====
// Euler step of one 2-D body with friction and a speed cap, Q16.16 fixed point.
// Input stream s_axis: one body per transfer (position, velocity, thrust
// direction and magnitude, speed limit, time step). Output stream m_axis:
// new position, new capped velocity, and a saturation flag in tuser.
// cfg_wr_en/cfg_wr_data load the friction coefficient; write it while idle.
// Throughput: one body per cycle while the receiver does not stall. The pipeline
// depth comes from the square root (one result bit per stage, 32 stages)
// followed by the restoring divide (one quotient bit per stage, 31 stages,
// both components side by side).
// When the receiver stalls the whole pipeline holds in place and s_axis_tready
// drops; nothing is lost or repeated. Bubbles do not collapse.
// Reset clears all valid bits and sets the friction coefficient to 1.0.
`default_nettype none
module euler_velocity_speed_cap (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [19:0]  cfg_wr_data,   // friction_coeff
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, dir_x, dir_y, accel_mag, speed_limit, step_time
    input  wire logic [247:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    output logic [127:0]      m_axis_tdata,
    output logic              m_axis_tuser   // saturated
);

    localparam int NT = evsc_pkg::TAIL_STAGES;
    localparam int SQ = evsc_pkg::SQRT_STAGES;
    localparam int DV = evsc_pkg::DIV_STAGES;
    localparam int NV = 5 + NT + 1;

    logic adv;
    logic [19:0] coeff_reg;
    logic [NV-1:0] vld_reg;
    logic out_vld_reg;

    assign adv = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coeff_reg <= 20'(evsc_pkg::COEFF_RESET);
        else if (cfg_wr_en)
            coeff_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NV-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[NV-1];
        end
    end

    // input fields
    logic signed [31:0] in_px, in_py, in_vx, in_vy, in_acc;
    logic signed [17:0] in_dx, in_dy;
    logic [30:0] in_lim;
    logic signed [16:0] in_st;
    logic signed [20:0] coeff_s;

    assign in_px   = s_axis_tdata[31:0];
    assign in_py   = s_axis_tdata[63:32];
    assign in_vx   = s_axis_tdata[95:64];
    assign in_vy   = s_axis_tdata[127:96];
    assign in_dx   = s_axis_tdata[145:128];
    assign in_dy   = s_axis_tdata[163:146];
    assign in_acc  = s_axis_tdata[195:164];
    assign in_lim  = s_axis_tdata[226:196];
    assign in_st   = {1'b0, s_axis_tdata[242:227]};
    assign coeff_s = {1'b0, coeff_reg};

    // stage A: products
    logic signed [31:0] a_px_reg, a_py_reg, a_vx_reg, a_vy_reg;
    logic [30:0] a_lim_reg;
    logic signed [16:0] a_st_reg;
    logic signed [48:0] a_mvx_reg, a_mvy_reg;
    logic signed [49:0] a_dax_reg, a_day_reg;
    logic signed [52:0] a_fvx_reg, a_fvy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_px_reg  <= in_px;
            a_py_reg  <= in_py;
            a_vx_reg  <= in_vx;
            a_vy_reg  <= in_vy;
            a_lim_reg <= in_lim;
            a_st_reg  <= in_st;
            a_mvx_reg <= in_vx * in_st;
            a_mvy_reg <= in_vy * in_st;
            a_dax_reg <= in_dx * in_acc;
            a_day_reg <= in_dy * in_acc;
            a_fvx_reg <= coeff_s * in_vx;
            a_fvy_reg <= coeff_s * in_vy;
        end
    end

    // stage B: new position, acceleration
    logic [32:0] b_satx, b_saty;
    logic signed [53:0] b_difx, b_dify;
    logic b_flag_reg;
    logic signed [31:0] b_npx_reg, b_npy_reg, b_vx_reg, b_vy_reg;
    logic [30:0] b_lim_reg;
    logic signed [16:0] b_st_reg;
    logic signed [37:0] b_ax_reg, b_ay_reg;

    always_comb
    begin
        b_satx = evsc_pkg::sat32(64'(a_px_reg) + 64'(a_mvx_reg >>> 16));
        b_saty = evsc_pkg::sat32(64'(a_py_reg) + 64'(a_mvy_reg >>> 16));
        b_difx = 54'(a_dax_reg) - 54'(a_fvx_reg);
        b_dify = 54'(a_day_reg) - 54'(a_fvy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_flag_reg <= b_satx[32] | b_saty[32];
            b_npx_reg  <= b_satx[31:0];
            b_npy_reg  <= b_saty[31:0];
            b_vx_reg   <= a_vx_reg;
            b_vy_reg   <= a_vy_reg;
            b_lim_reg  <= a_lim_reg;
            b_st_reg   <= a_st_reg;
            b_ax_reg   <= b_difx[53:16];
            b_ay_reg   <= b_dify[53:16];
        end
    end

    // stage C: acceleration times step
    logic c_flag_reg;
    logic signed [31:0] c_npx_reg, c_npy_reg, c_vx_reg, c_vy_reg;
    logic [30:0] c_lim_reg;
    logic signed [54:0] c_pax_reg, c_pay_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_flag_reg <= b_flag_reg;
            c_npx_reg  <= b_npx_reg;
            c_npy_reg  <= b_npy_reg;
            c_vx_reg   <= b_vx_reg;
            c_vy_reg   <= b_vy_reg;
            c_lim_reg  <= b_lim_reg;
            c_pax_reg  <= b_ax_reg * b_st_reg;
            c_pay_reg  <= b_ay_reg * b_st_reg;
        end
    end

    // stage D: uncapped velocity
    logic [32:0] d_satx, d_saty;
    logic d_flag_reg;
    logic signed [31:0] d_npx_reg, d_npy_reg, d_tx_reg, d_ty_reg;
    logic [30:0] d_lim_reg;

    always_comb
    begin
        d_satx = evsc_pkg::sat32(64'(c_vx_reg) + 64'(c_pax_reg >>> 16));
        d_saty = evsc_pkg::sat32(64'(c_vy_reg) + 64'(c_pay_reg >>> 16));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_flag_reg <= c_flag_reg | d_satx[32] | d_saty[32];
            d_npx_reg  <= c_npx_reg;
            d_npy_reg  <= c_npy_reg;
            d_tx_reg   <= d_satx[31:0];
            d_ty_reg   <= d_saty[31:0];
            d_lim_reg  <= c_lim_reg;
        end
    end

    // stage E: magnitudes squared, scaled dividends
    logic [31:0] e_ux, e_uy;
    logic e_flag_reg, e_negx_reg, e_negy_reg;
    logic signed [31:0] e_npx_reg, e_npy_reg, e_tx_reg, e_ty_reg;
    logic [63:0] e_sqx_reg, e_sqy_reg;
    logic [61:0] e_lim2_reg;
    logic [62:0] e_dvx_reg, e_dvy_reg;

    always_comb
    begin
        e_ux = d_tx_reg[31] ? 32'(-d_tx_reg) : 32'(d_tx_reg);
        e_uy = d_ty_reg[31] ? 32'(-d_ty_reg) : 32'(d_ty_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_flag_reg <= d_flag_reg;
            e_npx_reg  <= d_npx_reg;
            e_npy_reg  <= d_npy_reg;
            e_tx_reg   <= d_tx_reg;
            e_ty_reg   <= d_ty_reg;
            e_negx_reg <= d_tx_reg[31];
            e_negy_reg <= d_ty_reg[31];
            e_sqx_reg  <= 64'(e_ux) * 64'(e_ux);
            e_sqy_reg  <= 64'(e_uy) * 64'(e_uy);
            e_lim2_reg <= 62'(d_lim_reg) * 62'(d_lim_reg);
            e_dvx_reg  <= 63'(e_ux) * 63'(d_lim_reg);
            e_dvy_reg  <= 63'(e_uy) * 63'(d_lim_reg);
        end
    end

    // stage F: length squared, cap decision, seed the root and divide
    evsc_pkg::tail_t tail_reg [0:NT];
    evsc_pkg::tail_t f_next;

    always_comb
    begin
        f_next      = '0;
        f_next.flag = e_flag_reg;
        f_next.npx  = e_npx_reg;
        f_next.npy  = e_npy_reg;
        f_next.tx   = e_tx_reg;
        f_next.ty   = e_ty_reg;
        f_next.negx = e_negx_reg;
        f_next.negy = e_negy_reg;
        f_next.dvx  = e_dvx_reg;
        f_next.dvy  = e_dvy_reg;
        f_next.n    = e_sqx_reg + e_sqy_reg;
        f_next.cap  = (e_sqx_reg + e_sqy_reg) > 64'(e_lim2_reg);
        f_next.rx   = e_dvx_reg[62:31];
        f_next.ry   = e_dvy_reg[62:31];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            tail_reg[0] <= f_next;
    end

    for (genvar s = 1; s <= NT; s++)
    begin : g_tail
        evsc_pkg::tail_t cur, nxt;
        assign cur = tail_reg[s-1];

        if (s <= SQ)
        begin : g_sqrt
            localparam int K = s - 1;
            localparam logic [63:0] BITV = 64'(1) << (62 - 2 * K);
            logic [63:0] trial;

            always_comb
            begin
                trial = cur.res + BITV;
                nxt   = cur;
                if (cur.n >= trial)
                begin
                    nxt.n   = cur.n - trial;
                    nxt.res = (cur.res >> 1) + BITV;
                end
                else
                    nxt.res = cur.res >> 1;
            end
        end
        else
        begin : g_div
            localparam int J = DV - (s - SQ);
            logic [32:0] rtx, rty, len33;

            always_comb
            begin
                len33 = {1'b0, cur.res[31:0]};
                rtx   = {cur.rx, cur.dvx[J]};
                rty   = {cur.ry, cur.dvy[J]};
                nxt   = cur;
                if (rtx >= len33)
                begin
                    nxt.rx    = 32'(rtx - len33);
                    nxt.qx[J] = 1'b1;
                end
                else
                    nxt.rx = rtx[31:0];
                if (rty >= len33)
                begin
                    nxt.ry    = 32'(rty - len33);
                    nxt.qy[J] = 1'b1;
                end
                else
                    nxt.ry = rty[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                tail_reg[s] <= nxt;
        end
    end

    // output register: restore signs, pick capped or plain velocity
    evsc_pkg::tail_t last;
    logic [31:0] o_vx, o_vy;
    logic [127:0] out_data_reg;
    logic out_sat_reg;

    always_comb
    begin
        last = tail_reg[NT];
        if (last.cap)
        begin
            o_vx = last.negx ? 32'(-{1'b0, last.qx}) : {1'b0, last.qx};
            o_vy = last.negy ? 32'(-{1'b0, last.qy}) : {1'b0, last.qy};
        end
        else
        begin
            o_vx = last.tx;
            o_vy = last.ty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {o_vy, o_vx, last.npy, last.npx};
            out_sat_reg  <= last.flag;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/evsc_chk.sv =====
`default_nettype none
module evsc_chk (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [evsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input wire logic                                 m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // input side moves exactly when the output register can drain
    a_ready_tie: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // no transfer is taken in while a result is held back
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("input transfer during output stall");

endmodule

bind euler_velocity_speed_cap evsc_chk u_evsc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
